// ===== design/sbc_pkg.sv =====
// ---------------------------------------------------------------------------
// sbc_pkg: shared types, constants and functions of the bin compander
// Holds the item formats between the front, the queue and the back, the
// register indexes and the fixed-point helper functions.
// ---------------------------------------------------------------------------
package sbc_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SLOPE_LO  = 2'd1,
    CFG_SLOPE_HI  = 2'd2
  } cfg_idx_t;

  localparam int MAG_W      = 32;
  localparam int SLOPE_W    = 16;
  localparam int FRAC_W     = 16;  // fraction bits of log2 / exp2 values
  localparam int D_W        = 22;  // log2 difference, signed Q.16
  localparam int E_W        = 17;  // slope - 1, signed Q.12
  localparam int P_W        = D_W + E_W;
  localparam int Y_W        = P_W - 12;
  localparam int N_W        = Y_W - FRAC_W;
  localparam int FE_STAGES  = FRAC_W + 3;
  localparam int BE_STAGES  = FRAC_W + 3;
  localparam int FQ_DEPTH   = 4;
  localparam int FQ_AW      = 2;

  localparam logic signed [SLOPE_W-1:0] UNITY_SLOPE  = 16'sd4096;
  localparam logic signed [Y_W-1:0]     GAIN_LOG_LIM = 27'sd3265588;

  // how the back end treats an item
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_PASS,
    KIND_SCALE
  } kind_t;

  // item handed from front to back
  typedef struct packed {
    logic [MAG_W-1:0]         mag;
    logic                     fend;
    kind_t                    kind;
    logic signed [Y_W-1:0]    y;
  } item_t;

  // position of the most significant set bit (0 for zero)
  function automatic logic [4:0] msb_pos(input logic [MAG_W-1:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  // one squaring step of the log2 mantissa: {fraction bit, next mantissa}
  function automatic logic [MAG_W:0] sq_step(input logic [MAG_W-1:0] m);
    logic [2*MAG_W-1:0] sq;
    logic [MAG_W:0]     t;
    sq = m * m;
    t  = sq[2*MAG_W-1:31];
    return t[MAG_W] ? {1'b1, t[MAG_W:1]} : {1'b0, t[MAG_W-1:0]};
  endfunction

  // integer square root, used at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.31
  function automatic logic [31:0] exp_c(input int k);
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int i = 1; i <= FRAC_W; i++) begin
      if (i <= k) c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

endpackage

// ===== design/spectral_bin_compander_unit.sv =====
// ---------------------------------------------------------------------------
// spectral_bin_compander_unit: spectral magnitude compander
// Returns mag * (mag / threshold) ^ (slope - 1) for each FFT bin.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one bin per item, tdata = magnitude (Q16.16), tlast = frame end.
//   out_* : one companded magnitude per item, tlast copied from the input.
//   cfg_* : write threshold (index 0), slope below (1), slope above (2)
//           while no item is in flight; writes take effect at once.
// Throughput: one item per cycle while out_tready is high. The front
// takes log2 of magnitude and threshold in 16 squaring stages (two 32x32
// squarers per stage), the back builds exp2 in 16 multiply stages (one
// 32x32 multiplier per stage), so the pipe sustains one bin per clock
// while out_tready is high. Registers: 19 register stages in the front,
// 1 in the queue, 19 in the back.
// Reset: clears all valid bits and the queue, and loads threshold 1.0 and
// both slopes 1.0 (pass-through).
// Stall: when out_tready is low the back holds; the 4-entry queue absorbs
// the front until full, after which in_tready drops once the front's last stage holds an item.
// ---------------------------------------------------------------------------
module spectral_bin_compander_unit import sbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] magnitude_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] magnitude_out
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [MAG_W-1:0]          thr_r;
  logic signed [SLOPE_W-1:0] slb_r, sla_r;
  logic                      f_valid, f_ready, b_valid, b_ready;
  item_t                     f_item, b_item;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'h0001_0000;
      slb_r <= UNITY_SLOPE;
      sla_r <= UNITY_SLOPE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_THRESHOLD: thr_r <= cfg_wdata;
        CFG_SLOPE_LO:  slb_r <= cfg_wdata[SLOPE_W-1:0];
        CFG_SLOPE_HI:  sla_r <= cfg_wdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  sbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .mag_in    (in_tdata),
    .fend_in   (in_tlast),
    .threshold (thr_r),
    .slope_lo  (slb_r),
    .slope_hi  (sla_r),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  sbc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  sbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_item   (b_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .mag_out   (out_tdata),
    .fend_out  (out_tlast)
  );

endmodule

// ===== design/sbc_front.sv =====
// ---------------------------------------------------------------------------
// sbc_front: log-domain front end
// Normalizes magnitude and threshold, takes both log2 by repeated squaring,
// forms the log2 of the gain and classifies each item.
// ---------------------------------------------------------------------------
module sbc_front import sbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MAG_W-1:0]          mag_in,
  input  logic                      fend_in,
  input  logic [MAG_W-1:0]          threshold,
  input  logic signed [SLOPE_W-1:0] slope_lo,
  input  logic signed [SLOPE_W-1:0] slope_hi,
  output logic                      out_valid,
  input  logic                      out_ready,
  output item_t                     out_item
);

  typedef struct packed {
    logic [MAG_W-1:0]          mag;
    logic                      fend;
    logic                      below;
    logic signed [SLOPE_W-1:0] slope;
    logic [4:0]                pm;
    logic [4:0]                pt;
    logic [MAG_W-1:0]          mm;
    logic [MAG_W-1:0]          mt;
    logic [FRAC_W-1:0]         fm;
    logic [FRAC_W-1:0]         ft;
  } lg_t;

  typedef struct packed {
    logic [MAG_W-1:0]      mag;
    logic                  fend;
    logic                  below;
    logic                  unity;
    logic signed [P_W-1:0] prod;
  } pr_t;

  logic [FE_STAGES-1:0] vld_r;
  logic                 adv;
  lg_t                  lg_r [0:FRAC_W];
  lg_t                  lg_nxt [0:FRAC_W];
  pr_t                  pr_r, pr_nxt;
  item_t                it_r, it_nxt;
  logic [MAG_W-1:0]     thr;

  // advance the whole pipe unless the last item is stuck
  assign adv       = !vld_r[FE_STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[FE_STAGES-1];
  assign out_item  = it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[FE_STAGES-2:0], in_valid};
    end
  end

  // select region and normalize both mantissas
  always_comb begin
    thr                = (threshold == '0) ? MAG_W'(1) : threshold;
    lg_nxt[0].mag      = mag_in;
    lg_nxt[0].fend     = fend_in;
    lg_nxt[0].below    = mag_in < thr;
    lg_nxt[0].slope    = (mag_in < thr) ? slope_lo : slope_hi;
    lg_nxt[0].pm       = msb_pos(mag_in);
    lg_nxt[0].pt       = msb_pos(thr);
    lg_nxt[0].mm       = mag_in << (5'd31 - msb_pos(mag_in));
    lg_nxt[0].mt       = thr << (5'd31 - msb_pos(thr));
    lg_nxt[0].fm       = '0;
    lg_nxt[0].ft       = '0;
  end

  // square both mantissas, one fraction bit per stage
  for (genvar k = 1; k <= FRAC_W; k++) begin : g_sq
    logic [MAG_W:0] sm, st;
    always_comb begin
      sm        = sq_step(lg_r[k-1].mm);
      st        = sq_step(lg_r[k-1].mt);
      lg_nxt[k] = lg_r[k-1];
      lg_nxt[k].mm = sm[MAG_W-1:0];
      lg_nxt[k].mt = st[MAG_W-1:0];
      lg_nxt[k].fm = {lg_r[k-1].fm[FRAC_W-2:0], sm[MAG_W]};
      lg_nxt[k].ft = {lg_r[k-1].ft[FRAC_W-2:0], st[MAG_W]};
    end
  end

  for (genvar k = 0; k <= FRAC_W; k++) begin : g_lg
    always_ff @(posedge clk) begin
      if (adv) lg_r[k] <= lg_nxt[k];
    end
  end

  // scale the log difference by slope - 1
  always_comb begin
    logic signed [5:0]     pdiff;
    logic signed [D_W-1:0] d;
    logic signed [E_W-1:0] e;
    pdiff        = $signed({1'b0, lg_r[FRAC_W].pm}) - $signed({1'b0, lg_r[FRAC_W].pt});
    d            = $signed({pdiff, lg_r[FRAC_W].fm}) - $signed({6'b0, lg_r[FRAC_W].ft});
    e            = $signed({lg_r[FRAC_W].slope[SLOPE_W-1], lg_r[FRAC_W].slope}) -
                   $signed(E_W'(4096));
    pr_nxt.mag   = lg_r[FRAC_W].mag;
    pr_nxt.fend  = lg_r[FRAC_W].fend;
    pr_nxt.below = lg_r[FRAC_W].below;
    pr_nxt.unity = lg_r[FRAC_W].slope == UNITY_SLOPE;
    pr_nxt.prod  = P_W'(e) * P_W'(d);
  end

  // floor the gain log and classify the item
  always_comb begin
    logic signed [Y_W-1:0] y;
    y            = pr_r.prod[P_W-1:12];
    it_nxt.mag   = pr_r.mag;
    it_nxt.fend  = pr_r.fend;
    it_nxt.y     = y;
    priority if (pr_r.mag == '0) begin
      it_nxt.kind = KIND_ZERO;
    end else if (pr_r.unity) begin
      it_nxt.kind = KIND_PASS;
    end else if (pr_r.below && (y <= -GAIN_LOG_LIM || y >= GAIN_LOG_LIM)) begin
      it_nxt.kind = KIND_PASS;
    end else begin
      it_nxt.kind = KIND_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r <= pr_nxt;
      it_r <= it_nxt;
    end
  end

endmodule

// ===== design/sbc_fifo.sv =====
// ---------------------------------------------------------------------------
// sbc_fifo: short item queue between front and back
// Lets the front keep running while the back is stalled, and back.
// ---------------------------------------------------------------------------
module sbc_fifo import sbc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t            mem_r [0:FQ_DEPTH-1];
  logic [FQ_AW-1:0] wp_r, rp_r;
  logic [FQ_AW:0]   cnt_r;
  logic             push, pop;

  assign push_ready = cnt_r != (FQ_AW+1)'(FQ_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // store the incoming item
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FQ_AW+1)'(push) - (FQ_AW+1)'(pop);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FQ_AW+1)'(FQ_DEPTH)) else $error("queue overfilled");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == (FQ_AW+1)'(FQ_DEPTH)) |-> wp_r == rp_r)
    else $error("queue pointers out of step with count");
  a_pop_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && !pop_ready) |=> pop_valid && $stable(pop_item))
    else $error("queued item lost while back stalled");

endmodule

// ===== design/sbc_back.sv =====
// ---------------------------------------------------------------------------
// sbc_back: exp2 back end
// Builds the gain mantissa from the fraction of the gain log, multiplies
// it into the magnitude, shifts by the integer part and saturates.
// ---------------------------------------------------------------------------
module sbc_back import sbc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [MAG_W-1:0] mag_out,
  output logic             fend_out
);

  typedef struct packed {
    logic [MAG_W-1:0]      mag;
    logic                  fend;
    kind_t                 kind;
    logic signed [N_W-1:0] n;
    logic [FRAC_W-1:0]     f;
    logic [MAG_W-1:0]      m;
  } ex_t;

  typedef struct packed {
    logic [MAG_W-1:0]      mag;
    logic                  fend;
    kind_t                 kind;
    logic signed [N_W-1:0] n;
    logic [2*MAG_W-1:0]    prod;
  } pm_t;

  logic [BE_STAGES-1:0] vld_r;
  logic                 adv;
  ex_t                  ex_r [0:FRAC_W];
  ex_t                  ex_nxt [0:FRAC_W];
  pm_t                  pm_r;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic                 fend_r;
  kind_t                kind_r;

  assign adv       = !vld_r[BE_STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[BE_STAGES-1];
  assign mag_out   = mag_r;
  assign fend_out  = fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BE_STAGES-2:0], in_valid};
    end
  end

  // unpack the gain log, mantissa starts at one
  always_comb begin
    ex_nxt[0].mag  = in_item.mag;
    ex_nxt[0].fend = in_item.fend;
    ex_nxt[0].kind = in_item.kind;
    ex_nxt[0].n    = in_item.y[Y_W-1:FRAC_W];
    ex_nxt[0].f    = in_item.y[FRAC_W-1:0];
    ex_nxt[0].m    = 32'h8000_0000;
  end

  // multiply in 2^(2^-k) where fraction bit k is set
  for (genvar k = 1; k <= FRAC_W; k++) begin : g_ex
    localparam logic [MAG_W-1:0] CK = exp_c(k);
    logic [2*MAG_W-1:0] p;
    always_comb begin
      p         = ex_r[k-1].m * CK;
      ex_nxt[k] = ex_r[k-1];
      if (ex_r[k-1].f[FRAC_W-k]) ex_nxt[k].m = p[62:31];
    end
  end

  for (genvar k = 0; k <= FRAC_W; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) ex_r[k] <= ex_nxt[k];
    end
  end

  // apply the mantissa to the magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      pm_r.mag  <= ex_r[FRAC_W].mag;
      pm_r.fend <= ex_r[FRAC_W].fend;
      pm_r.kind <= ex_r[FRAC_W].kind;
      pm_r.n    <= ex_r[FRAC_W].n;
      pm_r.prod <= ex_r[FRAC_W].mag * ex_r[FRAC_W].m;
    end
  end

  // shift by the integer part and saturate
  always_comb begin
    logic [5:0]         sh;
    logic [2*MAG_W-1:0] r;
    sh = 6'(7'sd31 - 7'(pm_r.n));
    r  = pm_r.prod >> sh;
    unique case (pm_r.kind)
      KIND_ZERO: mag_nxt = '0;
      KIND_PASS: mag_nxt = pm_r.mag;
      KIND_SCALE: begin
        priority if (pm_r.n > N_W'(31)) begin
          mag_nxt = '1;
        end else if (pm_r.n < -N_W'(32)) begin
          mag_nxt = '0;
        end else if (r[2*MAG_W-1:MAG_W] != '0) begin
          mag_nxt = '1;
        end else begin
          mag_nxt = r[MAG_W-1:0];
        end
      end
      default: mag_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r  <= mag_nxt;
      fend_r <= pm_r.fend;
      kind_r <= pm_r.kind;
    end
  end

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind_r == KIND_ZERO) |-> mag_r == '0)
    else $error("zero magnitude produced nonzero result");
  a_pass_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[BE_STAGES-2] && pm_r.kind == KIND_PASS) |=> mag_r == $past(pm_r.mag))
    else $error("pass-through item altered");

endmodule
